/* rtl/d2e_pkg.sv */
// Shared types, constants and calendar tables for the date to epoch converter.
`timescale 1ns / 1ps
`default_nettype none

package d2e_pkg;

    // Calendar constants
    localparam int EPOCH_YEAR        = 1970;
    localparam int MAX_YEAR          = 3000;
    localparam int LEAPS_BELOW_EPOCH = 478;    // leap years in [0, 1970)
    localparam int SEC_PER_DAY       = 86400;
    localparam int SEC_PER_HOUR      = 3600;
    localparam int SEC_PER_MIN       = 60;
    localparam int DAYS_PER_YEAR     = 365;

    // Divide by 100 via reciprocal, exact for 12-bit operands
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Classified word handed from the front to the back
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        leap;
        logic [10:0] leap_cnt;   // leap years in [0, year)
        logic        valid;
    } d2e_word_t;

    // Queue fill status seen by both neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } d2e_qstat_t;

    // floor(x / 100) for x below 4096
    function automatic logic [5:0] div100(input logic [11:0] x);
        logic [24:0] prod;
        prod = 25'(x) * 25'(DIV100_MUL);
        return prod[24:DIV100_SHIFT];
    endfunction

    // Days in the month, leap February included; zero for a bad month
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month in a common year
    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* rtl/date_to_epoch_seconds_core.sv */
// Top level: Gregorian date and time to Unix seconds, front, queue and back.
//
//  channel | direction | handshake          | words
//  s_      | in        | s_valid / s_ready  | cal_year, cal_month, cal_day, clock_hour/minute/second
//  m_      | out       | m_valid / m_ready  | epoch_seconds, date_valid
//
// One word per cycle sustained while the output is not stalled; a word passes the front register,
// the queue, the day-count stage and the seconds multiply into the output register.
// The throughput is set by the front check and the two back stages.
// Synchronous active-low reset empties all stages and the queue.
// An output stall fills the back stages, then the queue (QUEUE_DEPTH words)
// and the front register, then drops s_ready.
`timescale 1ns / 1ps
`default_nettype none

module date_to_epoch_seconds_core import d2e_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [11:0] s_cal_year,
    input  wire logic [3:0]  s_cal_month,
    input  wire logic [4:0]  s_cal_day,
    input  wire logic [4:0]  s_clock_hour,
    input  wire logic [5:0]  s_clock_minute,
    input  wire logic [5:0]  s_clock_second,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_epoch_seconds,
    output logic             m_date_valid
);

    d2e_qstat_t q_stat;
    d2e_word_t  push_word, pop_word;
    logic       push, pop;

    d2e_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cal_year     (s_cal_year),
        .s_cal_month    (s_cal_month),
        .s_cal_day      (s_cal_day),
        .s_clock_hour   (s_clock_hour),
        .s_clock_minute (s_clock_minute),
        .s_clock_second (s_clock_second),
        .q_stat         (q_stat),
        .push           (push),
        .push_word      (push_word)
    );

    d2e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .q_stat    (q_stat)
    );

    d2e_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_stat          (q_stat),
        .pop_word        (pop_word),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_epoch_seconds (m_epoch_seconds),
        .m_date_valid    (m_date_valid)
    );

endmodule

`default_nettype wire

/* rtl/d2e_front.sv */
// Front end: accepts date words, range-checks them and counts leap years.
`timescale 1ns / 1ps
`default_nettype none

module d2e_front import d2e_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [11:0] s_cal_year,
    input  wire logic [3:0]  s_cal_month,
    input  wire logic [4:0]  s_cal_day,
    input  wire logic [4:0]  s_clock_hour,
    input  wire logic [5:0]  s_clock_minute,
    input  wire logic [5:0]  s_clock_second,
    input  wire d2e_qstat_t  q_stat,
    output logic             push,
    output d2e_word_t        push_word
);

    logic        f_valid_reg, f_valid_next;
    d2e_word_t   f_word_reg, f_word_next;
    logic        adv;

    logic [11:0] year_m1;
    logic [5:0]  q100_y, q100_m;
    logic [3:0]  q400_y, q400_m;
    logic        by100, by400, leap;
    logic [4:0]  mlen;
    logic        ok;

    // Stage moves when empty or when the queue takes its word
    assign push    = f_valid_reg && !q_stat.full;
    assign adv     = !f_valid_reg || !q_stat.full;
    assign s_ready = adv;

    // Leap rule: a year is a multiple of 100 (400) when its quotient
    // differs from that of the year before; year zero is leap
    always_comb begin
        year_m1 = s_cal_year - 12'd1;
        q100_y  = div100(s_cal_year);
        q100_m  = div100(year_m1);
        q400_y  = q100_y[5:2];
        q400_m  = q100_m[5:2];
        by100   = (q100_y != q100_m);
        by400   = (q400_y != q400_m);
        leap    = (s_cal_year == 12'd0) ||
                  ((s_cal_year[1:0] == 2'd0) && (!by100 || by400));
        mlen    = month_len(s_cal_month, leap);
        ok      = (s_cal_year <= 12'(MAX_YEAR)) &&
                  (s_cal_month inside {[4'd1:4'd12]}) &&
                  (s_cal_day != 5'd0) && (s_cal_day <= mlen) &&
                  (s_clock_hour <= 5'd24) &&
                  (s_clock_minute <= 6'd60) &&
                  (s_clock_second <= 6'd60);

        f_word_next.year   = s_cal_year;
        f_word_next.month  = s_cal_month;
        f_word_next.day    = s_cal_day;
        f_word_next.hour   = s_clock_hour;
        f_word_next.minute = s_clock_minute;
        f_word_next.second = s_clock_second;
        f_word_next.leap   = leap;
        f_word_next.valid  = ok;
        // leaps below y: 1 + (y-1)/4 - (y-1)/100 + (y-1)/400
        if (s_cal_year == 12'd0) begin
            f_word_next.leap_cnt = 11'd0;
        end else begin
            f_word_next.leap_cnt = 11'd1 + 11'(year_m1[11:2]) - 11'(q100_m) + 11'(q400_m);
        end

        f_valid_next = adv ? s_valid : f_valid_reg;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            f_word_reg <= f_word_next;
        end
    end

    assign push_word = f_word_reg;

endmodule

`default_nettype wire

/* rtl/d2e_queue.sv */
// Small FIFO that decouples the front end from the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none

module d2e_queue import d2e_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire d2e_word_t push_word,
    input  wire logic      pop,
    output d2e_word_t      pop_word,
    output d2e_qstat_t     q_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    d2e_word_t       mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    // Pointer wrap at DEPTH, count tracks occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    assign pop_word     = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    // No overflow or underflow
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < CW'(DEPTH)))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");
    // Occupancy never passes the depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

/* rtl/d2e_back.sv */
// Back end: day count, then seconds, into the output register.
`timescale 1ns / 1ps
`default_nettype none

module d2e_back import d2e_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire d2e_qstat_t q_stat,
    input  wire d2e_word_t pop_word,
    output logic           pop,
    output logic           m_valid,
    input  wire logic      m_ready,
    output logic [31:0]    m_epoch_seconds,
    output logic           m_date_valid
);

    // Stage 1 registers: days from epoch and seconds of day
    logic               b1_valid_reg, b1_valid_next;
    logic signed [21:0] b1_days_reg, b1_days_next;
    logic [16:0]        b1_tod_reg, b1_tod_next;
    logic               b1_ok_reg;

    // Output registers
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_secs_reg, out_secs_next;
    logic               out_ok_reg;

    logic               out_adv, b1_adv;
    logic signed [12:0] year_off;
    logic signed [21:0] year_days;
    logic [31:0]        days_ext;

    assign out_adv = !out_valid_reg || m_ready;
    assign b1_adv  = !b1_valid_reg || out_adv;
    assign pop     = b1_adv && !q_stat.empty;

    // Day count and time of day
    always_comb begin
        year_off     = $signed({1'b0, pop_word.year}) - 13'sd1970;
        year_days    = 22'(year_off) * 22'sd365;
        b1_days_next = year_days
                     + $signed({11'd0, pop_word.leap_cnt})
                     - 22'sd478
                     + $signed({13'd0, days_before(pop_word.month)})
                     + $signed({21'd0, pop_word.leap && (pop_word.month > 4'd2)})
                     + $signed({17'd0, pop_word.day})
                     - 22'sd1;
        b1_tod_next  = 17'(pop_word.hour) * 17'(SEC_PER_HOUR)
                     + 17'(pop_word.minute) * 17'(SEC_PER_MIN)
                     + 17'(pop_word.second);
        b1_valid_next = b1_adv ? !q_stat.empty : b1_valid_reg;
    end

    // Seconds modulo 2^32, zero for a rejected word
    always_comb begin
        days_ext      = {{10{b1_days_reg[21]}}, b1_days_reg};
        out_secs_next = b1_ok_reg ? (days_ext * 32'(SEC_PER_DAY) + 32'(b1_tod_reg)) : 32'd0;
        out_valid_next = out_adv ? b1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b1_days_reg <= b1_days_next;
            b1_tod_reg  <= b1_tod_next;
            b1_ok_reg   <= pop_word.valid;
        end
        if (out_adv && b1_valid_reg) begin
            out_secs_reg <= out_secs_next;
            out_ok_reg   <= b1_ok_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_epoch_seconds = out_secs_reg;
    assign m_date_valid    = out_ok_reg;

    // Rejected dates read as zero
    a_zero_on_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_date_valid) |-> (m_epoch_seconds == 32'd0))
        else $error("rejected date with nonzero seconds");
    // A word in stage 1 is held while the output is stalled
    a_b1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (b1_valid_reg && !out_adv) |=> (b1_valid_reg && $stable(b1_days_reg)))
        else $error("stage 1 word lost under stall");
    // A result word stays put until it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_epoch_seconds)
                                   && $stable(m_date_valid)))
        else $error("result word changed while stalled");

endmodule

`default_nettype wire

/* tb/tb_date_to_epoch_seconds_core.sv */
// Testbench for the date to epoch seconds converter: directed and random dates, self-checking.
`timescale 1ns / 1ps

module tb_date_to_epoch_seconds_core import d2e_pkg::*;;

    localparam int RAND_DATES   = 900;
    localparam int QUIET_TAIL   = 100;   // final words sent with no idling on either side
    localparam int DRAIN_CYCLES = 12;    // extra wait after the last result word

    // One date/time word plus its pacing
    typedef struct {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        bit          hold;   // wait for all results before sending
        int          gap;    // idle cycles after this word is taken
    } date_word_t;

    typedef struct {
        logic [31:0] epoch_seconds;
        logic        date_valid;
    } epoch_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [11:0] s_cal_year = '0;
    logic [3:0]  s_cal_month = '0;
    logic [4:0]  s_cal_day = '0;
    logic [4:0]  s_clock_hour = '0;
    logic [5:0]  s_clock_minute = '0;
    logic [5:0]  s_clock_second = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_epoch_seconds;
    logic        m_date_valid;

    date_word_t    date_q[$];    // words still to send
    epoch_result_t epoch_q[$];   // results owed by the block
    date_word_t    cur_date;
    int            stim_total = 0;
    int            dates_sent = 0;
    int            epochs_seen = 0;
    int            mismatch_cnt = 0;
    int            gap_left = 0;
    int            stall_left = 0;

    date_to_epoch_seconds_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cal_year      (s_cal_year),
        .s_cal_month     (s_cal_month),
        .s_cal_day       (s_cal_day),
        .s_clock_hour    (s_clock_hour),
        .s_clock_minute  (s_clock_minute),
        .s_clock_second  (s_clock_second),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_epoch_seconds (m_epoch_seconds),
        .m_date_valid    (m_date_valid)
    );

    always #10 aclk = ~aclk;

    // Gregorian leap rule; year 0 counts as leap
    function automatic bit gregorian_leap(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // Month length with leap February; 0 for a month outside 1..12
    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        int unsigned n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            2:                     n = gregorian_leap(y) ? 29 : 28;
            default:               n = 0;
        endcase
        return n;
    endfunction

    // Leap years in [0, n)
    function automatic longint leaps_before(longint n);
        longint k;
        if (n == 0) begin
            return 0;
        end
        k = n - 1;
        return 1 + k / 4 - k / 100 + k / 400;
    endfunction

    // Expected result for one date word
    function automatic epoch_result_t epoch_of(date_word_t w);
        epoch_result_t r;
        longint        yr;
        longint        days;
        longint        secs;
        int unsigned   mlen;
        r.epoch_seconds = '0;
        r.date_valid = 1'b0;
        yr = longint'(w.year);
        mlen = days_in_month(w.year, w.month);
        if (w.year > MAX_YEAR || mlen == 0 || w.day == 0 || w.day > mlen
                || w.hour > 24 || w.minute > 60 || w.second > 60) begin
            return r;
        end
        days = (yr - EPOCH_YEAR) * DAYS_PER_YEAR + leaps_before(yr) - leaps_before(EPOCH_YEAR);
        for (int k = 1; k < w.month; k++) begin
            days += longint'(days_in_month(w.year, k));
        end
        days += longint'(w.day) - 1;
        secs = days * SEC_PER_DAY + longint'(w.hour) * SEC_PER_HOUR
             + longint'(w.minute) * SEC_PER_MIN + longint'(w.second);
        r.epoch_seconds = secs[31:0];
        r.date_valid = 1'b1;
        return r;
    endfunction

    task automatic add_date(int y, int mo, int d, int h, int mi, int s);
        date_word_t w;
        w.year = 12'(y);
        w.month = 4'(mo);
        w.day = 5'(d);
        w.hour = 5'(h);
        w.minute = 6'(mi);
        w.second = 6'(s);
        w.hold = 1'b0;
        w.gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
        date_q.push_back(w);
    endtask

    // Driver: next word goes out once the previous one is taken and any gap is over
    always @(posedge aclk) begin
        date_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                epoch_q.push_back(epoch_of(cur_date));
                dates_sent <= dates_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (date_q.size() != 0 && (!date_q[0].hold ||
                        (!(s_valid && s_ready) && dates_sent == epochs_seen))) begin
                    w = date_q.pop_front();
                    cur_date = w;
                    s_cal_year <= w.year;
                    s_cal_month <= w.month;
                    s_cal_day <= w.day;
                    s_clock_hour <= w.hour;
                    s_clock_minute <= w.minute;
                    s_clock_second <= w.second;
                    s_valid <= 1'b1;
                    gap_left = w.gap;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result word against the oldest expectation, stall at random
    always @(posedge aclk) begin
        epoch_result_t e;
        int            stall_pct;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (epoch_q.size() == 0) begin
                    $error("result word with nothing expected: epoch_seconds %0h date_valid %0b",
                           m_epoch_seconds, m_date_valid);
                    mismatch_cnt++;
                end else begin
                    e = epoch_q.pop_front();
                    if (m_epoch_seconds !== e.epoch_seconds) begin
                        $error("epoch_seconds: expected %0h, actual %0h",
                               e.epoch_seconds, m_epoch_seconds);
                        mismatch_cnt++;
                    end
                    if (m_date_valid !== e.date_valid) begin
                        $error("date_valid: expected %0b, actual %0b",
                               e.date_valid, m_date_valid);
                        mismatch_cnt++;
                    end
                end
                epochs_seen <= epochs_seen + 1;
            end
            stall_pct = ((epochs_seen / 128) % 3 == 1) ? 0 : 25;
            if (dates_sent >= stim_total - QUIET_TAIL) begin
                stall_pct = 0;
                stall_left = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 10);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        date_word_t w;
        int         sel;
        int         y;
        int         mlen;
        int         gap_pct;

        // Directed: epoch, range edges, leap rules, wrap points, each rejection
        add_date(1970, 1, 1, 0, 0, 0);
        add_date(1969, 12, 31, 23, 59, 59);
        add_date(0, 1, 1, 0, 0, 0);
        add_date(0, 2, 29, 12, 30, 30);
        add_date(3000, 12, 31, 24, 60, 60);
        add_date(3001, 1, 1, 0, 0, 0);
        add_date(4095, 15, 31, 31, 63, 63);
        add_date(2000, 2, 29, 0, 0, 0);
        add_date(1900, 2, 29, 0, 0, 0);
        add_date(1900, 2, 28, 23, 59, 59);
        add_date(2024, 2, 29, 1, 2, 3);
        add_date(2023, 2, 29, 1, 2, 3);
        add_date(2038, 1, 19, 3, 14, 8);
        add_date(2106, 2, 7, 6, 28, 16);
        add_date(2100, 3, 1, 0, 0, 0);
        add_date(1600, 3, 1, 0, 0, 0);
        add_date(2020, 0, 10, 0, 0, 0);
        add_date(2020, 13, 10, 0, 0, 0);
        add_date(2020, 4, 0, 0, 0, 0);
        add_date(2020, 4, 31, 0, 0, 0);
        add_date(2020, 12, 31, 0, 0, 0);
        add_date(2020, 6, 15, 25, 0, 0);
        add_date(2020, 6, 15, 0, 61, 0);
        add_date(2020, 6, 15, 0, 0, 61);

        // Random: mostly well-formed dates, some with one field broken, some pure noise
        for (int i = 0; i < RAND_DATES; i++) begin
            case ($urandom_range(0, 3))
                0: y = $urandom_range(0, 3000);
                1: y = $urandom_range(1900, 2110);
                2: y = $urandom_range(0, 30) * 100 + $urandom_range(0, 8) - 4;
                default: y = ($urandom_range(0, 1) == 1) ? $urandom_range(2990, 3000)
                                                         : $urandom_range(0, 10);
            endcase
            if (y < 0) y = 0;
            if (y > 3000) y = 3000;
            w.year = 12'(y);
            w.month = 4'($urandom_range(1, 12));
            mlen = days_in_month(w.year, w.month);
            w.day = ($urandom_range(0, 3) == 0) ? 5'(mlen) : 5'($urandom_range(1, mlen));
            w.hour = 5'($urandom_range(0, 24));
            w.minute = 6'($urandom_range(0, 60));
            w.second = 6'($urandom_range(0, 60));
            sel = $urandom_range(0, 99);
            if (sel >= 90) begin
                w.year = 12'($urandom);
                w.month = 4'($urandom);
                w.day = 5'($urandom);
                w.hour = 5'($urandom);
                w.minute = 6'($urandom);
                w.second = 6'($urandom);
            end else if (sel >= 75) begin
                case ($urandom_range(0, 5))
                    0: w.year = 12'($urandom_range(3001, 4095));
                    1: w.month = ($urandom_range(0, 1) == 1) ? 4'd0 : 4'($urandom_range(13, 15));
                    2: w.day = (mlen == 31 || $urandom_range(0, 1) == 1)
                               ? 5'd0 : 5'($urandom_range(mlen + 1, 31));
                    3: w.hour = 5'($urandom_range(25, 31));
                    4: w.minute = 6'($urandom_range(61, 63));
                    default: w.second = 6'($urandom_range(61, 63));
                endcase
            end
            w.hold = (i % 150 == 0);
            gap_pct = ((i / 100) % 3 == 0) ? 0 : 25;
            w.gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 11) : 0;
            date_q.push_back(w);
        end

        // No idling over the tail of the run
        stim_total = date_q.size();
        for (int i = stim_total - QUIET_TAIL; i < stim_total; i++) begin
            date_q[i].gap = 0;
        end

        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (dates_sent != stim_total || epochs_seen != dates_sent) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (epoch_q.size() != 0) begin
            $error("%0d expected result words never arrived", epoch_q.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
